@@ rtl/ejm_pkg.sv @@
// shared types and constants of the extended job message parser
// no dependencies

package ejm_pkg;

    // result kinds
    localparam logic [3:0] KIND_CHAN      = 4'd0;
    localparam logic [3:0] KIND_JOB       = 4'd1;
    localparam logic [3:0] KIND_NTIMEFLAG = 4'd2;
    localparam logic [3:0] KIND_NTIME     = 4'd3;
    localparam logic [3:0] KIND_VER       = 4'd4;
    localparam logic [3:0] KIND_ROLL      = 4'd5;
    localparam logic [3:0] KIND_MCOUNT    = 4'd6;
    localparam logic [3:0] KIND_MBYTE     = 4'd7;
    localparam logic [3:0] KIND_PLEN      = 4'd8;
    localparam logic [3:0] KIND_PBYTE     = 4'd9;
    localparam logic [3:0] KIND_SLEN      = 4'd10;
    localparam logic [3:0] KIND_SBYTE     = 4'd11;
    localparam logic [3:0] KIND_STATUS    = 4'd12;

    localparam logic [7:0] NTIME_PRESENT  = 8'h01;
    localparam int         BRANCH_BYTES   = 32;

    localparam int DEF_MAX_BRANCHES     = 16;
    localparam int DEF_MAX_PREFIX_BYTES = 1024;
    localparam int DEF_MAX_SUFFIX_BYTES = 1024;

    localparam int QUEUE_DEPTH = 4;

    // what one input byte causes: an optional field and an optional status
    typedef struct packed {
        logic        has_field;
        logic [3:0]  kind;
        logic [31:0] value;
        logic [15:0] index;
        logic        has_status;
        logic        bad;
    } ejm_entry_t;

endpackage

@@ rtl/ejm_if.sv @@
// valid/ready channel interfaces for payload bytes and parsed results
// depends on nothing

interface ejm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ejm_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  field_kind;
    logic [31:0] field_value;
    logic [15:0] elem_index;
    logic        run_end;

    modport source (output valid, output field_kind, output field_value,
                    output elem_index, output run_end, input ready);
    modport sink   (input valid, input field_kind, input field_value,
                    input elem_index, input run_end, output ready);
endinterface

@@ rtl/ejm_front.sv @@
// front end: accepts payload bytes, tracks the field position, builds queue entries
// depends on ejm_pkg and ejm_byte_if

module ejm_front
    import ejm_pkg::*;
#(
    parameter int MAX_BRANCHES     = DEF_MAX_BRANCHES,
    parameter int MAX_PREFIX_BYTES = DEF_MAX_PREFIX_BYTES,
    parameter int MAX_SUFFIX_BYTES = DEF_MAX_SUFFIX_BYTES
)
(
    input  logic         clk,
    input  logic         rst_n,
    ejm_byte_if.sink     bytes,
    input  logic         q_full,
    output logic         push,
    output ejm_entry_t   push_entry
);

    localparam logic [3:0] PH_CHAN   = 4'd0;
    localparam logic [3:0] PH_JOB    = 4'd1;
    localparam logic [3:0] PH_FLAG   = 4'd2;
    localparam logic [3:0] PH_NTIME  = 4'd3;
    localparam logic [3:0] PH_VER    = 4'd4;
    localparam logic [3:0] PH_ROLL   = 4'd5;
    localparam logic [3:0] PH_MCOUNT = 4'd6;
    localparam logic [3:0] PH_MBYTE  = 4'd7;
    localparam logic [3:0] PH_PLEN   = 4'd8;
    localparam logic [3:0] PH_PBYTE  = 4'd9;
    localparam logic [3:0] PH_SLEN   = 4'd10;
    localparam logic [3:0] PH_SBYTE  = 4'd11;
    localparam logic [3:0] PH_DONE   = 4'd12;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] remain_reg, remain_next;
    logic        err_reg, err_next;
    logic        done_reg, done_next;

    logic        accept;
    logic [7:0]  b;
    logic [1:0]  pos;
    logic [31:0] gval;
    logic [15:0] cnt_inc;
    logic [15:0] remain_dec;
    logic [15:0] pos_inc;
    logic        fv;
    logic [3:0]  fkind;
    logic [31:0] fvalue;
    logic [15:0] findex;

    assign bytes.ready = !q_full;
    assign accept      = bytes.valid && !q_full;
    assign b           = bytes.data_byte;
    assign pos         = cnt_reg[1:0];
    assign gval        = acc_reg | ({24'd0, b} << {pos, 3'b000});
    assign cnt_inc     = cnt_reg + 16'd1;
    assign remain_dec  = remain_reg - 16'd1;
    assign pos_inc     = {14'd0, pos} + 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        err_next    = err_reg;
        done_next   = done_reg;
        fv          = 1'b0;
        fkind       = KIND_CHAN;
        fvalue      = gval;
        findex      = 16'd0;

        case (phase_reg)
            PH_CHAN, PH_JOB, PH_NTIME, PH_VER:
            begin
                if (pos == 2'd3)
                begin
                    fv       = 1'b1;
                    acc_next = 32'd0;
                    cnt_next = 16'd0;
                    case (phase_reg)
                        PH_CHAN:
                        begin
                            fkind      = KIND_CHAN;
                            phase_next = PH_JOB;
                        end
                        PH_JOB:
                        begin
                            fkind      = KIND_JOB;
                            phase_next = PH_FLAG;
                        end
                        PH_NTIME:
                        begin
                            fkind      = KIND_NTIME;
                            phase_next = PH_VER;
                        end
                        default:
                        begin
                            fkind      = KIND_VER;
                            phase_next = PH_ROLL;
                        end
                    endcase
                end
                else
                begin
                    acc_next = gval;
                    cnt_next = pos_inc;
                end
            end
            PH_FLAG:
            begin
                fv         = 1'b1;
                fkind      = KIND_NTIMEFLAG;
                fvalue     = {31'd0, b == NTIME_PRESENT};
                phase_next = (b == NTIME_PRESENT) ? PH_NTIME : PH_VER;
            end
            PH_ROLL:
            begin
                fv         = 1'b1;
                fkind      = KIND_ROLL;
                fvalue     = {31'd0, b != 8'd0};
                phase_next = PH_MCOUNT;
            end
            PH_MCOUNT:
            begin
                fv     = 1'b1;
                fkind  = KIND_MCOUNT;
                fvalue = {24'd0, b};
                if ({24'd0, b} > 32'(MAX_BRANCHES))
                begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end
                else if (b == 8'd0)
                begin
                    phase_next = PH_PLEN;
                end
                else
                begin
                    remain_next = 16'({8'd0, b} * 16'(BRANCH_BYTES));
                    cnt_next    = 16'd0;
                    phase_next  = PH_MBYTE;
                end
            end
            PH_PLEN, PH_SLEN:
            begin
                if (pos != 2'd0)
                begin
                    fv       = 1'b1;
                    fkind    = (phase_reg == PH_PLEN) ? KIND_PLEN : KIND_SLEN;
                    acc_next = 32'd0;
                    cnt_next = 16'd0;
                    if (phase_reg == PH_PLEN)
                    begin
                        if (gval > 32'(MAX_PREFIX_BYTES))
                        begin
                            err_next   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (gval == 32'd0)
                        begin
                            phase_next = PH_SLEN;
                        end
                        else
                        begin
                            remain_next = gval[15:0];
                            phase_next  = PH_PBYTE;
                        end
                    end
                    else
                    begin
                        if (gval > 32'(MAX_SUFFIX_BYTES))
                        begin
                            err_next   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (gval == 32'd0)
                        begin
                            done_next  = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            remain_next = gval[15:0];
                            phase_next  = PH_SBYTE;
                        end
                    end
                end
                else
                begin
                    acc_next = gval;
                    cnt_next = pos_inc;
                end
            end
            PH_MBYTE, PH_PBYTE, PH_SBYTE:
            begin
                fv          = 1'b1;
                fvalue      = {24'd0, b};
                findex      = cnt_reg;
                cnt_next    = cnt_inc;
                remain_next = remain_dec;
                case (phase_reg)
                    PH_MBYTE: fkind = KIND_MBYTE;
                    PH_PBYTE: fkind = KIND_PBYTE;
                    default:  fkind = KIND_SBYTE;
                endcase
                if (remain_dec == 16'd0)
                begin
                    cnt_next = 16'd0;
                    case (phase_reg)
                        PH_MBYTE: phase_next = PH_PLEN;
                        PH_PBYTE: phase_next = PH_SLEN;
                        default:
                        begin
                            done_next  = 1'b1;
                            phase_next = PH_DONE;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        push_entry.has_field  = fv;
        push_entry.kind       = fkind;
        push_entry.value      = fvalue;
        push_entry.index      = findex;
        push_entry.has_status = bytes.last_byte;
        push_entry.bad        = err_next || !done_next;

        // final byte: status goes out and the next byte starts a new message
        if (bytes.last_byte)
        begin
            phase_next  = PH_CHAN;
            cnt_next    = 16'd0;
            acc_next    = 32'd0;
            remain_next = 16'd0;
            err_next    = 1'b0;
            done_next   = 1'b0;
        end
    end

    assign push = accept && (fv || bytes.last_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CHAN;
            cnt_reg    <= 16'd0;
            acc_reg    <= 32'd0;
            remain_reg <= 16'd0;
            err_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            remain_reg <= remain_next;
            err_reg    <= err_next;
            done_reg   <= done_next;
        end
    end

endmodule

@@ rtl/ejm_queue.sv @@
// short queue between front and back end
// depends on ejm_pkg

module ejm_queue
    import ejm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ejm_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       empty,
    output ejm_entry_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ejm_entry_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop) else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

@@ rtl/ejm_back.sv @@
// back end: splits queue entries into result items, holds them in the output register
// depends on ejm_pkg and ejm_result_if

module ejm_back
    import ejm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  ejm_entry_t    head,
    output logic          pop,
    ejm_result_if.source  results
);

    logic        valid_reg;
    logic [3:0]  kind_reg;
    logic [31:0] value_reg;
    logic [15:0] index_reg;
    logic        run_end_reg;
    logic        pend_reg;
    logic        pend_bad_reg;
    logic        load;

    assign results.valid       = valid_reg;
    assign results.field_kind  = kind_reg;
    assign results.field_value = value_reg;
    assign results.elem_index  = index_reg;
    assign results.run_end     = run_end_reg;

    assign load = !valid_reg || results.ready;
    // a waiting status has priority over the next entry
    assign pop  = load && !pend_reg && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else if (!q_empty)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= head.has_field && head.has_status;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                kind_reg    <= KIND_STATUS;
                value_reg   <= {31'd0, pend_bad_reg};
                index_reg   <= 16'd0;
                run_end_reg <= 1'b1;
            end
            else if (!q_empty)
            begin
                pend_bad_reg <= head.bad;
                if (head.has_field)
                begin
                    kind_reg    <= head.kind;
                    value_reg   <= head.value;
                    index_reg   <= head.index;
                    run_end_reg <= !head.has_status;
                end
                else
                begin
                    kind_reg    <= KIND_STATUS;
                    value_reg   <= {31'd0, head.bad};
                    index_reg   <= 16'd0;
                    run_end_reg <= 1'b1;
                end
            end
        end
    end

    a_pend_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> valid_reg) else $error("status pending without a field in the register");
    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && kind_reg == KIND_STATUS |-> run_end_reg)
        else $error("status item without run end");
    a_open_run_pending: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !run_end_reg |-> pend_reg)
        else $error("open run with no status waiting");

endmodule

@@ rtl/extended_job_message_parser.sv @@
// extended job message parser: byte stream in, parsed field items out
// depends on ejm_pkg, ejm_if, ejm_front, ejm_queue and ejm_back
//
// bytes: one payload byte per item, last_byte set on the final byte of the payload.
// results: one item per completed field (channel id, job id, ntime flag, ntime,
// version, rolling flag, merkle count and bytes, prefix and suffix lengths and
// bytes) and exactly one status item at the final byte (value 0 ok, 1 error).
// run_end marks the last result caused by one byte; a byte causes zero, one or
// two results (the field it completes, then the status).
// a result goes into the queue when its byte is accepted, then into the output
// register; a status that follows a field is loaded once the field is taken.
// throughput: one byte per cycle; the results of a byte leave one after the other,
// and a four-entry queue between the byte parser and the output stage absorbs
// them. ready drops only while that queue is full.
// if the receiver stalls, the output register holds its item and the queue fills;
// then bytes are refused until space frees up.
// reset clears the parse position, the queue and the output register; the
// next byte is the first byte of a message. after the final byte the parser
// starts over by itself.

module extended_job_message_parser
    import ejm_pkg::*;
#(
    parameter int MAX_BRANCHES     = DEF_MAX_BRANCHES,
    parameter int MAX_PREFIX_BYTES = DEF_MAX_PREFIX_BYTES,
    parameter int MAX_SUFFIX_BYTES = DEF_MAX_SUFFIX_BYTES
)
(
    input  logic          clk,
    input  logic          rst_n,
    ejm_byte_if.sink      bytes,
    ejm_result_if.source  results
);

    logic       q_full;
    logic       q_empty;
    logic       push;
    logic       pop;
    ejm_entry_t push_entry;
    ejm_entry_t head;

    ejm_front #(
        .MAX_BRANCHES     (MAX_BRANCHES),
        .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES),
        .MAX_SUFFIX_BYTES (MAX_SUFFIX_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    ejm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    ejm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

@@ test/tb_extended_job_message_parser.sv @@
// testbench for extended_job_message_parser: payload byte items in, parsed field items out
// depends on ejm_pkg, ejm_if and the parser rtl
`timescale 1ns / 1ps

module tb_extended_job_message_parser;
    import ejm_pkg::*;

    localparam int BRANCH_LIMIT   = DEF_MAX_BRANCHES;
    localparam int PREFIX_LIMIT   = DEF_MAX_PREFIX_BYTES;
    localparam int SUFFIX_LIMIT   = DEF_MAX_SUFFIX_BYTES;
    localparam int ITEM_TARGET    = 1950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [3:0] {
        ST_CHAN, ST_JOB, ST_FLAG, ST_NTIME, ST_VER, ST_ROLL, ST_MCOUNT,
        ST_MBYTE, ST_PLEN, ST_PBYTE, ST_SLEN, ST_SBYTE, ST_DONE
    } parse_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [15:0] index;
        logic        run_end;
    } field_item_t;

    logic clk;
    logic rst_n;

    ejm_byte_if   bytes_if();
    ejm_result_if results_if();

    extended_job_message_parser u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if),
        .results (results_if)
    );

    byte_item_t  pending_bytes[$];
    field_item_t expected_fields[$];
    field_item_t want;
    int          fail_count = 0;
    int          idle_cycles;
    int          send_gap;
    int          hold_gap;
    logic        progress;

    // parser state as seen by the predictor
    parse_state_t pr_phase    = ST_CHAN;
    logic [15:0]  pr_count    = '0;
    logic [31:0]  pr_acc      = '0;
    logic [15:0]  pr_remain   = '0;
    logic         pr_error    = 1'b0;
    logic         pr_complete = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // little-endian field assembly, returns 1 once nbytes have been gathered
    function automatic logic gather(input logic [7:0] b, input int nbytes,
                                    output logic [31:0] v);
        int pos;
        pos    = pr_count[1:0];
        pr_acc = pr_acc | (32'(b) << (8 * pos));
        v      = pr_acc;
        if (pos + 1 >= nbytes)
        begin
            pr_acc   = '0;
            pr_count = '0;
            return 1'b1;
        end
        pr_count = 16'(pos + 1);
        return 1'b0;
    endfunction

    function automatic field_item_t mk_field(input logic [3:0] kind, input logic [31:0] value,
                                             input logic [15:0] index);
        field_item_t f;
        f.kind    = kind;
        f.value   = value;
        f.index   = index;
        f.run_end = 1'b0;
        return f;
    endfunction

    function automatic field_item_t region_field(input logic [3:0] kind, input logic [7:0] b);
        field_item_t f;
        f         = mk_field(kind, 32'(b), pr_count);
        pr_count  = pr_count + 16'd1;
        pr_remain = pr_remain - 16'd1;
        return f;
    endfunction

    function automatic void open_region(input int size, input parse_state_t next);
        pr_remain = 16'(size);
        pr_count  = '0;
        pr_phase  = next;
    endfunction

    // works out the field items that one accepted payload byte causes
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        field_item_t out[$];
        logic [31:0] v;
        v = '0;
        case (pr_phase)
            ST_CHAN:
                if (gather(b, 4, v))
                begin
                    out.push_back(mk_field(KIND_CHAN, v, '0));
                    pr_phase = ST_JOB;
                end
            ST_JOB:
                if (gather(b, 4, v))
                begin
                    out.push_back(mk_field(KIND_JOB, v, '0));
                    pr_phase = ST_FLAG;
                end
            ST_FLAG:
            begin
                out.push_back(mk_field(KIND_NTIMEFLAG, 32'(b == NTIME_PRESENT), '0));
                pr_phase = (b == NTIME_PRESENT) ? ST_NTIME : ST_VER;
            end
            ST_NTIME:
                if (gather(b, 4, v))
                begin
                    out.push_back(mk_field(KIND_NTIME, v, '0));
                    pr_phase = ST_VER;
                end
            ST_VER:
                if (gather(b, 4, v))
                begin
                    out.push_back(mk_field(KIND_VER, v, '0));
                    pr_phase = ST_ROLL;
                end
            ST_ROLL:
            begin
                out.push_back(mk_field(KIND_ROLL, 32'(b != 8'd0), '0));
                pr_phase = ST_MCOUNT;
            end
            ST_MCOUNT:
            begin
                out.push_back(mk_field(KIND_MCOUNT, 32'(b), '0));
                if (b > BRANCH_LIMIT)
                begin
                    pr_error = 1'b1;
                    pr_phase = ST_DONE;
                end
                else if (b == 8'd0)
                    pr_phase = ST_PLEN;
                else
                    open_region(b * BRANCH_BYTES, ST_MBYTE);
            end
            ST_MBYTE:
            begin
                out.push_back(region_field(KIND_MBYTE, b));
                if (pr_remain == 16'd0)
                begin
                    pr_count = '0;
                    pr_phase = ST_PLEN;
                end
            end
            ST_PLEN:
                if (gather(b, 2, v))
                begin
                    out.push_back(mk_field(KIND_PLEN, v, '0));
                    if (v > PREFIX_LIMIT)
                    begin
                        pr_error = 1'b1;
                        pr_phase = ST_DONE;
                    end
                    else if (v == 0)
                        pr_phase = ST_SLEN;
                    else
                        open_region(v, ST_PBYTE);
                end
            ST_PBYTE:
            begin
                out.push_back(region_field(KIND_PBYTE, b));
                if (pr_remain == 16'd0)
                begin
                    pr_count = '0;
                    pr_phase = ST_SLEN;
                end
            end
            ST_SLEN:
                if (gather(b, 2, v))
                begin
                    out.push_back(mk_field(KIND_SLEN, v, '0));
                    if (v > SUFFIX_LIMIT)
                    begin
                        pr_error = 1'b1;
                        pr_phase = ST_DONE;
                    end
                    else if (v == 0)
                    begin
                        pr_complete = 1'b1;
                        pr_phase    = ST_DONE;
                    end
                    else
                        open_region(v, ST_SBYTE);
                end
            ST_SBYTE:
            begin
                out.push_back(region_field(KIND_SBYTE, b));
                if (pr_remain == 16'd0)
                begin
                    pr_count    = '0;
                    pr_complete = 1'b1;
                    pr_phase    = ST_DONE;
                end
            end
            default: ;
        endcase
        if (fin)
        begin
            out.push_back(mk_field(KIND_STATUS, 32'(pr_error || !pr_complete), '0));
            pr_phase    = ST_CHAN;
            pr_count    = '0;
            pr_acc      = '0;
            pr_remain   = '0;
            pr_error    = 1'b0;
            pr_complete = 1'b0;
        end
        if (out.size() > 0)
            out[out.size() - 1].run_end = 1'b1;
        foreach (out[i])
            expected_fields.push_back(out[i]);
    endfunction

    function automatic void push_le(ref logic [7:0] q[$], input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            q.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void push_random(ref logic [7:0] q[$], input int n);
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom));
    endfunction

    // builds one message; keep > 0 cuts it short, extra appends trailing bytes
    function automatic void add_message(input logic [31:0] chan, input logic [31:0] job,
                                        input logic [7:0] flag, input logic [31:0] ntime,
                                        input logic [31:0] ver, input logic [7:0] roll,
                                        input logic [7:0] mcount, input logic [15:0] plen,
                                        input logic [15:0] slen, input int keep,
                                        input int extra);
        logic [7:0] msg[$];
        byte_item_t it;
        push_le(msg, chan, 4);
        push_le(msg, job, 4);
        msg.push_back(flag);
        if (flag == NTIME_PRESENT)
            push_le(msg, ntime, 4);
        push_le(msg, ver, 4);
        msg.push_back(roll);
        msg.push_back(mcount);
        // past an over-limit count the parser ignores the rest, so stop building there
        if (mcount <= BRANCH_LIMIT)
        begin
            push_random(msg, mcount * BRANCH_BYTES);
            push_le(msg, 32'(plen), 2);
            if (plen <= PREFIX_LIMIT)
            begin
                push_random(msg, plen);
                push_le(msg, 32'(slen), 2);
                if (slen <= SUFFIX_LIMIT)
                    push_random(msg, slen);
            end
        end
        while (keep > 0 && msg.size() > keep)
            msg.delete(msg.size() - 1);
        push_random(msg, extra);
        foreach (msg[i])
        begin
            it.data = msg[i];
            it.last = (i == msg.size() - 1);
            pending_bytes.push_back(it);
        end
    endfunction

    function automatic int pick_len(input int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 6);
        else if (r < 97)
            return $urandom_range(7, 64);
        return $urandom_range(65, lim);
    endfunction

    function automatic logic [7:0] pick_flag();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return NTIME_PRESENT;
        else if (r < 8)
            return 8'h00;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_roll();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'h01;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_mcount();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, 1));
        return 8'($urandom_range(2, BRANCH_LIMIT));
    endfunction

    // no idling near the end, and in regular stretches along the way
    function automatic logic no_idle();
        return (pending_bytes.size() < 250) || ((pending_bytes.size() / 150) % 4 == 0);
    endfunction

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_if.valid     <= 1'b0;
            bytes_if.data_byte <= '0;
            bytes_if.last_byte <= 1'b0;
            send_gap           <= 0;
        end
        else if (!bytes_if.valid || bytes_if.ready)
        begin
            if (send_gap > 0)
            begin
                send_gap       <= send_gap - 1;
                bytes_if.valid <= 1'b0;
            end
            else if (!no_idle() && $urandom_range(0, 7) == 0)
            begin
                send_gap       <= $urandom_range(0, 8);
                bytes_if.valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                bytes_if.valid     <= 1'b1;
                bytes_if.data_byte <= pending_bytes[0].data;
                bytes_if.last_byte <= pending_bytes[0].last;
                pending_bytes.delete(0);
            end
            else
                bytes_if.valid <= 1'b0;
        end
    end

    // result receiver with stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
            hold_gap         <= 0;
        end
        else if (hold_gap > 0)
        begin
            hold_gap         <= hold_gap - 1;
            results_if.ready <= 1'b0;
        end
        else if (!no_idle() && $urandom_range(0, 5) == 0)
        begin
            hold_gap         <= $urandom_range(0, 8);
            results_if.ready <= 1'b0;
        end
        else
            results_if.ready <= 1'b1;
    end

    // monitor: checks result items, predicts from accepted bytes, watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            progress = 1'b0;
            if (results_if.valid && results_if.ready)
            begin
                progress = 1'b1;
                if (expected_fields.size() == 0)
                begin
                    $error("result item with nothing expected: kind %0d value %0h",
                           results_if.field_kind, results_if.field_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_fields.pop_front();
                    if (results_if.field_kind !== want.kind)
                    begin
                        $error("field_kind: expected %0d, got %0d",
                               want.kind, results_if.field_kind);
                        fail_count++;
                    end
                    if (results_if.field_value !== want.value)
                    begin
                        $error("field_value: expected %0h, got %0h",
                               want.value, results_if.field_value);
                        fail_count++;
                    end
                    if (results_if.elem_index !== want.index)
                    begin
                        $error("elem_index: expected %0d, got %0d",
                               want.index, results_if.elem_index);
                        fail_count++;
                    end
                    if (results_if.run_end !== want.run_end)
                    begin
                        $error("run_end: expected %0b, got %0b",
                               want.run_end, results_if.run_end);
                        fail_count++;
                    end
                end
            end
            if (bytes_if.valid && bytes_if.ready)
            begin
                progress = 1'b1;
                decode_byte(bytes_if.data_byte, bytes_if.last_byte);
            end
            if (progress)
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int r;
        int n;
        byte_item_t it;

        rst_n               = 1'b0;
        bytes_if.valid      = 1'b0;
        bytes_if.data_byte  = '0;
        bytes_if.last_byte  = 1'b0;
        results_if.ready    = 1'b0;

        // directed: value extremes, both flag paths, empty and single-entry regions
        add_message(32'hFFFF_FFFF, 32'h0, NTIME_PRESENT, 32'h8000_0001, 32'hFFFF_FFFF,
                    8'h00, 8'd0, 16'd0, 16'd0, 0, 0);
        add_message(32'h0, 32'hFFFF_FFFF, 8'h00, 32'h0, 32'h0, 8'hFF, 8'd1, 16'd1, 16'd1, 0, 0);
        // flag byte other than the ntime marker, then trailing bytes
        add_message($urandom, $urandom, 8'h02, 32'h0, $urandom, 8'h80, 8'd0, 16'd2, 16'd3, 0, 3);
        // over-limit counts and lengths, with ignored bytes after them
        add_message($urandom, $urandom, 8'h00, 32'h0, $urandom, 8'h01, 8'd17, 16'd0, 16'd0, 0, 3);
        add_message($urandom, $urandom, 8'h00, 32'h0, $urandom, 8'h01, 8'd255, 16'd0, 16'd0,
                    0, 0);
        add_message($urandom, $urandom, 8'h00, 32'h0, $urandom, 8'h00, 8'd0, 16'd1025, 16'd0,
                    0, 2);
        add_message($urandom, $urandom, NTIME_PRESENT, $urandom, $urandom, 8'h00, 8'd0,
                    16'hFFFF, 16'd0, 0, 0);
        add_message($urandom, $urandom, 8'h00, 32'h0, $urandom, 8'h00, 8'd0, 16'd0, 16'd1025,
                    0, 1);
        add_message($urandom, $urandom, 8'h00, 32'h0, $urandom, 8'h00, 8'd0, 16'd0, 16'hFFFF,
                    0, 0);
        // largest allowed sizes, cut short so the payload ends early
        add_message($urandom, $urandom, 8'h00, 32'h0, $urandom, 8'h00, 8'd16, 16'd0, 16'd0,
                    25, 0);
        add_message($urandom, $urandom, 8'h00, 32'h0, $urandom, 8'h00, 8'd0, 16'd1024, 16'd0,
                    22, 0);
        add_message($urandom, $urandom, 8'h00, 32'h0, $urandom, 8'h00, 8'd0, 16'd0, 16'd1024,
                    23, 0);
        // final byte inside channel id, job id and ntime
        add_message($urandom, $urandom, 8'h00, 32'h0, $urandom, 8'h00, 8'd0, 16'd0, 16'd0, 1, 0);
        add_message($urandom, $urandom, 8'h00, 32'h0, $urandom, 8'h00, 8'd0, 16'd0, 16'd0, 6, 0);
        add_message($urandom, $urandom, NTIME_PRESENT, $urandom, $urandom, 8'h00, 8'd0,
                    16'd0, 16'd0, 12, 0);

        while (pending_bytes.size() < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                add_message($urandom, $urandom, pick_flag(), $urandom, $urandom, pick_roll(),
                            pick_mcount(), 16'(pick_len(PREFIX_LIMIT)),
                            16'(pick_len(SUFFIX_LIMIT)), 0,
                            ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
            else if (r < 80)
            begin
                n = $urandom_range(0, 2);
                add_message($urandom, $urandom, pick_flag(), $urandom, $urandom, pick_roll(),
                            (n == 0) ? 8'($urandom_range(BRANCH_LIMIT + 1, 255)) : pick_mcount(),
                            (n == 1) ? 16'($urandom_range(PREFIX_LIMIT + 1, 65535))
                                     : 16'(pick_len(PREFIX_LIMIT)),
                            (n == 2) ? 16'($urandom_range(SUFFIX_LIMIT + 1, 65535))
                                     : 16'(pick_len(SUFFIX_LIMIT)),
                            0, $urandom_range(0, 6));
            end
            else if (r < 92)
                add_message($urandom, $urandom, pick_flag(), $urandom, $urandom, pick_roll(),
                            pick_mcount(), 16'(pick_len(PREFIX_LIMIT)),
                            16'(pick_len(SUFFIX_LIMIT)), $urandom_range(1, 40), 0);
            else
            begin
                // loose bytes with stray final-byte marks; the run ends on one
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                begin
                    it.data = 8'($urandom);
                    it.last = (i == n - 1) || ($urandom_range(0, 3) == 0);
                    pending_bytes.push_back(it);
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || bytes_if.valid || expected_fields.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_fields.size() != 0)
        begin
            $error("%0d expected result items never arrived", expected_fields.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ extended_job_message_parser.f @@
rtl/ejm_pkg.sv
rtl/ejm_if.sv
rtl/ejm_front.sv
rtl/ejm_queue.sv
rtl/ejm_back.sv
rtl/extended_job_message_parser.sv
test/tb_extended_job_message_parser.sv
